// File: hdl/ekts_pkg.sv
// Package for the exact L2 top-k search core: sizes, op codes, list entry types.
// Used by every module in hdl/; depends on nothing.
package ekts_pkg;

  localparam int MAX_DIM = 128;
  localparam int MAX_K   = 64;
  localparam int ID_BITS = 20;

  localparam int VAL_W  = 16;
  localparam int DIST_W = 39;
  localparam int K_W    = 7;
  localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CNT_W  = $clog2(MAX_K + 1);

  localparam logic [K_W-1:0]    K_RESET  = K_W'(10);
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  typedef enum logic [1:0] {
    OP_QUERY  = 2'd0,
    OP_BASE   = 2'd1,
    OP_FINISH = 2'd2
  } op_t;

  // one slot of the sorted list, also used for an insert candidate
  typedef struct packed {
    logic                vld;
    logic [DIST_W-1:0]   dsq;
    logic [ID_BITS-1:0]  id;
  } ent_t;

  typedef struct packed {
    logic clear;
    logic shift;
  } cell_ctl_t;

  function automatic logic ranks_before(input logic [DIST_W-1:0] da,
                                        input logic [ID_BITS-1:0] ia,
                                        input logic [DIST_W-1:0] db,
                                        input logic [ID_BITS-1:0] ib);
    return (da < db) || ((da == db) && (ia < ib));
  endfunction

endpackage

// File: hdl/ekts_dist.sv
// Distance front end: query store, component index, vector ids and the
// squared-difference accumulate pipeline. Depends on ekts_pkg.
module ekts_dist import ekts_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             acc_i,
  input  logic [1:0]       op_i,
  input  logic [VAL_W-1:0] val_i,
  input  logic             last_i,
  output ent_t             ins_o,
  output logic             fin_o
);

  logic [VAL_W-1:0]   mem [MAX_DIM];
  logic [VAL_W-1:0]   rd1_r;

  logic [IDX_W-1:0]   idx_r;
  logic [ID_BITS-1:0] vcnt_r;

  logic               base1_r, last1_r, fin1_r;
  logic [VAL_W-1:0]   val1_r;
  logic [ID_BITS-1:0] id1_r;

  logic               base2_r, last2_r, fin2_r;
  logic [ID_BITS-1:0] id2_r;
  logic [VAL_W-1:0]   mag2_r;

  logic               base3_r, last3_r, fin3_r;
  logic [ID_BITS-1:0] id3_r;
  logic [2*VAL_W-1:0] sq3_r;

  logic [DIST_W-1:0]  sum_r;
  logic               ins_vld_r, fin_r;
  logic [DIST_W-1:0]  ins_dist_r;
  logic [ID_BITS-1:0] ins_id_r;

  op_t                op;
  logic [IDX_W-1:0]   idx_nxt;
  logic [VAL_W:0]     diff;
  logic [VAL_W:0]     diff_abs;
  logic [DIST_W:0]    sum_wide;
  logic [DIST_W-1:0]  sum_sat;

  assign op = op_t'(op_i);

  always_comb begin
    if (last_i) begin
      idx_nxt = '0;
    end else if (idx_r < IDX_W'(MAX_DIM - 1)) begin
      idx_nxt = idx_r + IDX_W'(1);
    end else begin
      idx_nxt = idx_r;
    end
  end

  // query store, registered read every cycle
  always_ff @(posedge clk) begin
    if (acc_i && op == OP_QUERY) begin
      mem[idx_r] <= val_i;
    end
    rd1_r <= mem[idx_r];
  end

  assign diff     = {val1_r[VAL_W-1], val1_r} - {rd1_r[VAL_W-1], rd1_r};
  assign diff_abs = diff[VAL_W] ? (~diff + (VAL_W+1)'(1)) : diff;

  assign sum_wide = {1'b0, sum_r} + (DIST_W+1)'(sq3_r);
  assign sum_sat  = (sum_wide > {1'b0, DIST_MAX}) ? DIST_MAX : sum_wide[DIST_W-1:0];

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r     <= '0;
      vcnt_r    <= '0;
      base1_r   <= 1'b0;
      fin1_r    <= 1'b0;
      base2_r   <= 1'b0;
      fin2_r    <= 1'b0;
      base3_r   <= 1'b0;
      fin3_r    <= 1'b0;
      sum_r     <= '0;
      ins_vld_r <= 1'b0;
      fin_r     <= 1'b0;
    end else begin
      base1_r <= 1'b0;
      fin1_r  <= 1'b0;
      if (acc_i) begin
        unique case (op)
          OP_QUERY: begin
            idx_r <= idx_nxt;
          end
          OP_BASE: begin
            idx_r   <= idx_nxt;
            base1_r <= 1'b1;
            if (last_i) begin
              vcnt_r <= vcnt_r + ID_BITS'(1);
            end
          end
          OP_FINISH: begin
            idx_r  <= '0;
            vcnt_r <= '0;
            fin1_r <= 1'b1;
          end
          default: begin
          end
        endcase
      end
      base2_r <= base1_r;
      fin2_r  <= fin1_r;
      base3_r <= base2_r;
      fin3_r  <= fin2_r;

      ins_vld_r <= base3_r && last3_r;
      fin_r     <= fin3_r;
      if (fin3_r || (base3_r && last3_r)) begin
        sum_r <= '0;
      end else if (base3_r) begin
        sum_r <= sum_sat;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    val1_r     <= val_i;
    last1_r    <= last_i;
    id1_r      <= vcnt_r;
    last2_r    <= last1_r;
    id2_r      <= id1_r;
    mag2_r     <= diff_abs[VAL_W-1:0];
    last3_r    <= last2_r;
    id3_r      <= id2_r;
    sq3_r      <= mag2_r * mag2_r;
    ins_dist_r <= sum_sat;
    ins_id_r   <= id3_r;
  end

  assign ins_o = '{vld: ins_vld_r, dsq: ins_dist_r, id: ins_id_r};
  assign fin_o = fin_r;

endmodule

// File: hdl/ekts_cell.sv
// One slot of the sorted best list: compares the broadcast candidate with its
// own entry and trades entries with its neighbors. Depends on ekts_pkg.
module ekts_cell import ekts_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cell_ctl_t ctl_i,
  input  ent_t      cand_i,
  input  ent_t      left_i,
  input  logic      left_better_i,
  input  ent_t      right_i,
  output ent_t      ent_o,
  output logic      better_o
);

  logic               vld_r, vld_nxt;
  logic [DIST_W-1:0]  dist_r, dist_nxt;
  logic [ID_BITS-1:0] id_r, id_nxt;

  // an empty slot loses to any valid candidate
  assign better_o = cand_i.vld && (!vld_r || ranks_before(cand_i.dsq, cand_i.id, dist_r, id_r));

  always_comb begin
    vld_nxt  = vld_r;
    dist_nxt = dist_r;
    id_nxt   = id_r;
    priority if (ctl_i.clear) begin
      vld_nxt = 1'b0;
    end else if (ctl_i.shift) begin
      vld_nxt  = right_i.vld;
      dist_nxt = right_i.dsq;
      id_nxt   = right_i.id;
    end else if (better_o) begin
      if (left_better_i) begin
        vld_nxt  = left_i.vld;
        dist_nxt = left_i.dsq;
        id_nxt   = left_i.id;
      end else begin
        vld_nxt  = 1'b1;
        dist_nxt = cand_i.dsq;
        id_nxt   = cand_i.id;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dist_r <= dist_nxt;
    id_r   <= id_nxt;
  end

  assign ent_o = '{vld: vld_r, dsq: dist_r, id: id_r};

endmodule

// File: hdl/exact_l2_topk_search_core.sv
// Top level of the exact L2 top-k search core: config register, emit control
// and the row of list cells. Depends on ekts_pkg, ekts_dist, ekts_cell.
//
//   channel | ports                    | direction | handshake
//   --------+--------------------------+-----------+-------------------
//   in      | in_op/value/last         | request   | in_valid/in_ready
//   out     | out_result_valid/id/dist | result    | out_valid/out_ready
//   cfg     | cfg_wdata (k_in_use)     | write     | cfg_we, no wait
//
// Query and base components: one request per cycle; four-stage distance pipe
// (store read, difference, square, accumulate), then a parallel insert across
// all MAX_K cells. A finish request holds in_ready low while the pipe drains
// and while the results are emitted, each result gated by out_ready.
// Synchronous active-low reset empties the list; the query store is not reset.
module exact_l2_topk_search_core import ekts_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_op,
  input  logic [VAL_W-1:0]   in_component_value,
  input  logic               in_last_component,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_result_valid,
  output logic [ID_BITS-1:0] out_neighbour_id,
  output logic [DIST_W-1:0]  out_neighbour_distance,
  output logic               out_last_result,
  input  logic               cfg_we,
  input  logic [K_W-1:0]     cfg_wdata
);

  typedef enum logic [1:0] {S_RUN, S_WAIT, S_EMIT} state_t;

  state_t             state_r;
  logic [K_W-1:0]     k_r;
  logic [CNT_W-1:0]   cnt_r, rem_r;
  logic               empty_r;
  logic               out_valid_r, out_rv_r, out_last_r;
  logic [ID_BITS-1:0] out_id_r;
  logic [DIST_W-1:0]  out_dist_r;

  logic               in_acc;
  ent_t               ins;
  logic               fin_tok;
  cell_ctl_t          ctl;
  ent_t               ents    [MAX_K];
  logic               betters [MAX_K];
  logic [MAX_K-1:0]   vld_vec;
  logic [CNT_W-1:0]   kk, n_sel;
  logic               emit_go, last_now;

  assign in_ready = (state_r == S_RUN);
  assign in_acc   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= K_RESET;
    end else if (cfg_we) begin
      k_r <= cfg_wdata;
    end
  end

  ekts_dist u_dist (
    .clk    (clk),
    .rst_n  (rst_n),
    .acc_i  (in_acc),
    .op_i   (in_op),
    .val_i  (in_component_value),
    .last_i (in_last_component),
    .ins_o  (ins),
    .fin_o  (fin_tok)
  );

  for (genvar i = 0; i < MAX_K; i++) begin : g_cell
    ent_t left_e, right_e;
    logic left_b;
    if (i == 0) begin : g_head
      assign left_e = '0;
      assign left_b = 1'b0;
    end else begin : g_body
      assign left_e = ents[i-1];
      assign left_b = betters[i-1];
    end
    if (i == MAX_K - 1) begin : g_tail
      assign right_e = '0;
    end else begin : g_next
      assign right_e = ents[i+1];
    end
    ekts_cell u_cell (
      .clk           (clk),
      .rst_n         (rst_n),
      .ctl_i         (ctl),
      .cand_i        (ins),
      .left_i        (left_e),
      .left_better_i (left_b),
      .right_i       (right_e),
      .ent_o         (ents[i]),
      .better_o      (betters[i])
    );
    assign vld_vec[i] = ents[i].vld;
  end

  // k of 0 acts as 1, above MAX_K as MAX_K
  always_comb begin
    if (k_r == '0) begin
      kk = CNT_W'(1);
    end else if (k_r > K_W'(MAX_K)) begin
      kk = CNT_W'(MAX_K);
    end else begin
      kk = CNT_W'(k_r);
    end
    n_sel = (cnt_r < kk) ? cnt_r : kk;
  end

  assign emit_go  = (state_r == S_EMIT) && (!out_valid_r || out_ready);
  assign last_now = empty_r || (rem_r == CNT_W'(1));
  assign ctl      = '{clear: emit_go && last_now, shift: emit_go && !empty_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_RUN;
      cnt_r       <= '0;
      rem_r       <= '0;
      empty_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ins.vld && cnt_r < CNT_W'(MAX_K)) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      // a new result loaded below keeps out_valid_r high
      if (out_valid_r && out_ready && !emit_go) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_RUN: begin
          if (in_acc && op_t'(in_op) == OP_FINISH) begin
            state_r <= S_WAIT;
          end
        end
        S_WAIT: begin
          // finish token leaves the pipe after every earlier insert
          if (fin_tok) begin
            state_r <= S_EMIT;
            rem_r   <= n_sel;
            empty_r <= (n_sel == '0);
          end
        end
        S_EMIT: begin
          if (emit_go) begin
            out_valid_r <= 1'b1;
            out_rv_r    <= !empty_r;
            out_id_r    <= empty_r ? '0 : ents[0].id;
            out_dist_r  <= empty_r ? '0 : ents[0].dsq;
            out_last_r  <= last_now;
            rem_r       <= rem_r - CNT_W'(1);
            if (last_now) begin
              state_r <= S_RUN;
              cnt_r   <= '0;
            end
          end
        end
        default: begin
          state_r <= S_RUN;
        end
      endcase
    end
  end

  assign out_valid              = out_valid_r;
  assign out_result_valid       = out_rv_r;
  assign out_neighbour_id       = out_id_r;
  assign out_neighbour_distance = out_dist_r;
  assign out_last_result        = out_last_r;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_K))
    else $error("list count above MAX_K");

  a_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    (({1'b0, vld_vec} & ({1'b0, vld_vec} + (MAX_K+1)'(1))) == '0))
    else $error("occupied cells not contiguous from the head");

  // the list drains from the head while emitting; the count clears at the end
  a_cnt_match: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_EMIT) |-> ($countones(vld_vec) == int'(cnt_r)))
    else $error("list count disagrees with occupied cells");

  a_fin_wait: assert property (@(posedge clk) disable iff (!rst_n)
    fin_tok |-> state_r == S_WAIT)
    else $error("finish token outside wait state");

endmodule
